// ===== design/msex_pkg.sv =====
// Shared types, constants and operation codes of the MIPS subset execute unit.
package msex_pkg;

  // Field widths
  localparam int WORD_W    = 32;
  localparam int OP_W      = 5;
  localparam int REG_NUM_W = 5;
  localparam int SHAMT_W   = 5;
  localparam int MEM_IDX_W = 8;

  // Program counter: index space is a power of two, so wrapping is a truncation
  localparam int PROGRAM_WORDS = 1024;
  localparam int IDX_W         = $clog2(PROGRAM_WORDS);
  localparam int WORD_SHIFT    = 2;
  localparam int BRANCH_SHIFT  = 2;
  localparam int JUMP_W        = IDX_W + WORD_SHIFT;

  // Storage defaults
  localparam int REG_COUNT_DEF  = 32;
  localparam int DATA_WORDS_DEF = 256;

  // Configuration register reset values
  localparam logic [WORD_W-1:0] CODE_BASE_RST = 32'd128;
  localparam logic [WORD_W-1:0] DATA_BASE_RST = 32'd256;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 1'd1;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_NOP     = 5'd0,
    OP_J       = 5'd1,
    OP_JR      = 5'd2,
    OP_BEQ     = 5'd3,
    OP_BLTZ    = 5'd4,
    OP_BGTZ    = 5'd5,
    OP_BREAK   = 5'd6,
    OP_SW      = 5'd7,
    OP_LW      = 5'd8,
    OP_SLL     = 5'd9,
    OP_SRL     = 5'd10,
    OP_SRA     = 5'd11,
    OP_ADD     = 5'd12,
    OP_SUB     = 5'd13,
    OP_MUL     = 5'd14,
    OP_AND     = 5'd15,
    OP_OR      = 5'd16,
    OP_XOR     = 5'd17,
    OP_NOR     = 5'd18,
    OP_SLT     = 5'd19,
    OP_ADDI    = 5'd20,
    OP_ANDI    = 5'd21,
    OP_SUBI    = 5'd22,
    OP_MULI    = 5'd23,
    OP_NORI    = 5'd24,
    OP_SLTI    = 5'd25,
    OP_PRELOAD = 5'd26
  } op_t;

  // Instruction as held in the execute stage
  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [REG_NUM_W-1:0] src_reg;
    logic [REG_NUM_W-1:0] second_reg;
    logic [REG_NUM_W-1:0] dest_reg;
    logic [SHAMT_W-1:0]   shift_amount;
    logic [WORD_W-1:0]    immediate;
    logic [WORD_W-1:0]    preload_word;
    logic [WORD_W-1:0]    imm_off;       // immediate minus data base address
  } inst_t;

  // Execute stage outcome
  typedef struct packed {
    logic [IDX_W-1:0]     next_index;
    logic                 halted;
    logic                 reg_written;
    logic [REG_NUM_W-1:0] written_reg;
    logic [WORD_W-1:0]    value;         // zero for loads, filled from memory later
    logic                 load;
    logic                 mem_written;
    logic                 mem_read;
    logic [WORD_W-1:0]    mem_index;
    logic [WORD_W-1:0]    mem_data;
  } exec_t;

  // Result item as carried by the memory stage and the output register
  typedef struct packed {
    logic [IDX_W-1:0]     executed_index;
    logic [IDX_W-1:0]     next_index;
    logic                 halted;
    logic                 reg_written;
    logic [REG_NUM_W-1:0] written_reg;
    logic [WORD_W-1:0]    written_value;
    logic                 mem_written;
    logic [MEM_IDX_W-1:0] mem_word_index;
  } res_t;

endpackage

// ===== design/msex_if.sv =====
// Handshake channel interfaces: instruction in, result out, configuration write.
interface msex_inst_if import msex_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [REG_NUM_W-1:0] src_reg;
  logic [REG_NUM_W-1:0] second_reg;
  logic [REG_NUM_W-1:0] dest_reg;
  logic [SHAMT_W-1:0]   shift_amount;
  logic [WORD_W-1:0]    immediate;
  logic [WORD_W-1:0]    preload_word;

  modport source (output valid, operation, src_reg, second_reg, dest_reg, shift_amount,
                  immediate, preload_word, input ready);
  modport sink   (input valid, operation, src_reg, second_reg, dest_reg, shift_amount,
                  immediate, preload_word, output ready);
endinterface

interface msex_result_if import msex_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     executed_index;
  logic [IDX_W-1:0]     next_index;
  logic                 halted;
  logic                 reg_written;
  logic [REG_NUM_W-1:0] written_reg;
  logic [WORD_W-1:0]    written_value;
  logic                 mem_written;
  logic [MEM_IDX_W-1:0] mem_word_index;

  modport source (output valid, executed_index, next_index, halted, reg_written,
                  written_reg, written_value, mem_written, mem_word_index, input ready);
  modport sink   (input valid, executed_index, next_index, halted, reg_written,
                  written_reg, written_value, mem_written, mem_word_index, output ready);
endinterface

interface msex_cfg_if import msex_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/msex_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/msex_alu.sv =====
// Execute stage logic: branch and jump targets, ALU ops, memory address and range checks.
module msex_alu import msex_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  inst_t             inst,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [IDX_W-1:0]  cur_index,
  input  logic              halt_flag,
  input  logic [WORD_W-1:0] code_base,
  output exec_t             ex
);

  op_t               op;
  logic [IDX_W-1:0]  nxt_seq;
  logic [IDX_W-1:0]  br_tgt;
  logic [JUMP_W-1:0] j_diff;
  logic [JUMP_W-1:0] jr_diff;
  logic [WORD_W-1:0] addr_off;
  logic [WORD_W-1:0] word_k;
  logic              k_ok;
  logic              pre_ok;
  logic [WORD_W-1:0] mul_rhs;
  logic [WORD_W-1:0] prod;

  assign op = op_t'(inst.operation);

  // Sequential and branch targets; the index wraps by truncation
  assign nxt_seq = cur_index + IDX_W'(1);
  assign br_tgt  = nxt_seq + inst.immediate[IDX_W+BRANCH_SHIFT-1:BRANCH_SHIFT];

  // Jump targets, only the bits that survive the shift and wrap
  assign j_diff  = inst.immediate[JUMP_W-1:0] - code_base[JUMP_W-1:0];
  assign jr_diff = a[JUMP_W-1:0] - code_base[JUMP_W-1:0];

  // Data word index relative to the data base
  assign addr_off = a + inst.imm_off;
  assign word_k   = addr_off >> WORD_SHIFT;
  assign k_ok     = (word_k < WORD_W'(DATA_WORDS));
  assign pre_ok   = (inst.immediate < WORD_W'(DATA_WORDS));

  // One shared multiplier for mul and muli
  assign mul_rhs = (op == OP_MULI) ? inst.immediate : b;
  assign prod    = a * mul_rhs;

  always_comb begin
    ex             = '0;
    ex.next_index  = nxt_seq;
    ex.halted      = halt_flag;
    ex.mem_index   = word_k;

    if (op == OP_PRELOAD) begin
      // Preload works even when halted and leaves the index alone
      ex.next_index = cur_index;
      ex.mem_index  = inst.immediate;
      if (pre_ok) begin
        ex.mem_written = 1'b1;
        ex.mem_data    = inst.preload_word;
      end
    end else if (halt_flag) begin
      ex.next_index = cur_index;
    end else begin
      case (op)
        OP_J:     ex.next_index = j_diff[JUMP_W-1:WORD_SHIFT];
        OP_JR:    ex.next_index = jr_diff[JUMP_W-1:WORD_SHIFT];
        OP_BEQ: begin
          if (a == b) ex.next_index = br_tgt;
        end
        OP_BLTZ: begin
          if ($signed(a) < 0) ex.next_index = br_tgt;
        end
        OP_BGTZ: begin
          if ($signed(a) > 0) ex.next_index = br_tgt;
        end
        OP_BREAK: ex.halted = 1'b1;
        OP_SW: begin
          if (k_ok) begin
            ex.mem_written = 1'b1;
            ex.mem_data    = b;
          end
        end
        OP_LW: begin
          if (k_ok) begin
            ex.mem_read    = 1'b1;
            ex.load        = 1'b1;
            ex.reg_written = 1'b1;
            ex.written_reg = inst.second_reg;
          end
        end
        OP_SLL: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg;
          ex.value = b << inst.shift_amount;
        end
        OP_SRL: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg;
          ex.value = b >> inst.shift_amount;
        end
        OP_SRA: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg;
          ex.value = WORD_W'($signed(b) >>> inst.shift_amount);
        end
        OP_ADD: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = a + b;
        end
        OP_SUB: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = a - b;
        end
        OP_MUL: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = prod;
        end
        OP_AND: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = a & b;
        end
        OP_OR: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = a | b;
        end
        OP_XOR: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = a ^ b;
        end
        OP_NOR: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg; ex.value = ~(a | b);
        end
        OP_SLT: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.dest_reg;
          ex.value = WORD_W'($signed(a) < $signed(b));
        end
        OP_ADDI: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.second_reg;
          ex.value = a + inst.immediate;
        end
        OP_ANDI: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.second_reg;
          ex.value = a & inst.immediate;
        end
        OP_SUBI: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.second_reg;
          ex.value = a - inst.immediate;
        end
        OP_MULI: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.second_reg; ex.value = prod;
        end
        OP_NORI: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.second_reg;
          ex.value = ~(a | inst.immediate);
        end
        OP_SLTI: begin
          ex.reg_written = 1'b1; ex.written_reg = inst.second_reg;
          ex.value = WORD_W'($signed(a) < $signed(inst.immediate));
        end
        default: ;
      endcase
    end

    // Writes to registers beyond the file are dropped
    if (ex.reg_written && (WORD_W'(ex.written_reg) >= WORD_W'(REG_COUNT))) begin
      ex.reg_written = 1'b0;
      ex.load        = 1'b0;
      ex.mem_read    = 1'b0;
    end
    if (!ex.reg_written) begin
      ex.written_reg = '0;
      ex.value       = '0;
    end
  end

endmodule

// ===== design/mips_subset_execute_unit.sv =====
// Top level of the MIPS subset execute unit: register read, execute, memory and result stages.
//
//   channel  dir  handshake      carries
//   inst     in   valid/ready    one pre-decoded instruction or preload per item
//   result   out  valid/ready    executed and next index, halt, register and memory writes
//   cfg      in   valid/ready    register index and write data (code base, data base)
//
// One item per cycle while the result channel is not stalled; an accepted item passes the
// input register with register file read, the execute register with data memory access
// and the result register at write back before its result is offered.
// Register file writes at write back are forwarded to the execute stage.
// After reset a clearing pass zeroes data memory and register file, one entry a
// cycle; inst.ready is low while it runs.
// A stalled result holds the whole pipeline; cfg is always ready.
module mips_subset_execute_unit import msex_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input logic         clk,
  input logic         rst,
  msex_inst_if.sink   inst,
  msex_result_if.source result,
  msex_cfg_if.sink    cfg
);

  localparam int RA_W    = $clog2(REG_COUNT);
  localparam int DA_W    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int CLR_LEN = (DATA_WORDS > REG_COUNT) ? DATA_WORDS : REG_COUNT;
  localparam int CW      = $clog2(CLR_LEN);

  // Configuration registers
  logic [WORD_W-1:0] code_base;
  logic [WORD_W-1:0] data_base;

  // Architectural state
  logic [IDX_W-1:0] program_index;
  logic             halt_flag;

  // Clearing pass
  logic          clearing;
  logic [CW-1:0] clr_cnt;

  // Pipeline control
  logic en;
  logic accept;
  logic s1_valid;
  logic s2_valid;
  logic out_valid;

  // Pipeline payload
  inst_t             s1;
  logic              s1_rs_ok;
  logic              s1_rt_ok;
  res_t              s2;
  logic              s2_load;
  res_t              out_q;
  logic [WORD_W-1:0] s2_wval;

  // Write-back bypass captured at the edge the execute-stage item was read
  logic                 fwd_valid;
  logic [REG_NUM_W-1:0] fwd_num;
  logic [WORD_W-1:0]    fwd_val;

  // Register file and data memory ports
  logic [WORD_W-1:0] rf_a_q;
  logic [WORD_W-1:0] rf_b_q;
  logic              rf_we;
  logic [RA_W-1:0]   rf_waddr;
  logic [WORD_W-1:0] rf_wdata;
  logic              dm_we;
  logic [DA_W-1:0]   dm_waddr;
  logic [WORD_W-1:0] dm_wdata;
  logic [WORD_W-1:0] dm_rdata;

  logic [WORD_W-1:0] op_a;
  logic [WORD_W-1:0] op_b;
  exec_t             ex;
  logic              rf_wb;

  // Handshakes
  assign en         = !out_valid || result.ready;
  assign inst.ready = en && !clearing;
  assign accept     = inst.valid && inst.ready;
  assign cfg.ready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      code_base <= CODE_BASE_RST;
      data_base <= DATA_BASE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CODE_BASE: code_base <= cfg.data;
        CFG_DATA_BASE: data_base <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CW'(CLR_LEN - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + CW'(1);
    end
  end

  // Register file: two copies, one per read port, written together
  assign rf_wb    = en && s2_valid && s2.reg_written;
  assign rf_we    = clearing ? ((CW + 1)'(clr_cnt) < (CW + 1)'(REG_COUNT)) : rf_wb;
  assign rf_waddr = clearing ? clr_cnt[RA_W-1:0] : s2.written_reg[RA_W-1:0];
  assign rf_wdata = clearing ? '0 : s2_wval;

  msex_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (en),
    .raddr (inst.src_reg[RA_W-1:0]),
    .rdata (rf_a_q)
  );

  msex_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (en),
    .raddr (inst.second_reg[RA_W-1:0]),
    .rdata (rf_b_q)
  );

  // Operand selection: write back first, then bypass latch, then the file
  always_comb begin
    if (s2_valid && s2.reg_written && (s2.written_reg == s1.src_reg)) begin
      op_a = s2_wval;
    end else if (fwd_valid && (fwd_num == s1.src_reg)) begin
      op_a = fwd_val;
    end else if (s1_rs_ok) begin
      op_a = rf_a_q;
    end else begin
      op_a = '0;
    end
  end

  always_comb begin
    if (s2_valid && s2.reg_written && (s2.written_reg == s1.second_reg)) begin
      op_b = s2_wval;
    end else if (fwd_valid && (fwd_num == s1.second_reg)) begin
      op_b = fwd_val;
    end else if (s1_rt_ok) begin
      op_b = rf_b_q;
    end else begin
      op_b = '0;
    end
  end

  // Execute
  msex_alu #(.REG_COUNT(REG_COUNT), .DATA_WORDS(DATA_WORDS)) u_alu (
    .inst      (s1),
    .a         (op_a),
    .b         (op_b),
    .cur_index (program_index),
    .halt_flag (halt_flag),
    .code_base (code_base),
    .ex        (ex)
  );

  // Data memory, accessed as the item leaves the execute stage
  assign dm_we    = clearing ? ((CW + 1)'(clr_cnt) < (CW + 1)'(DATA_WORDS))
                             : (en && s1_valid && ex.mem_written);
  assign dm_waddr = clearing ? clr_cnt[DA_W-1:0] : ex.mem_index[DA_W-1:0];
  assign dm_wdata = clearing ? '0 : ex.mem_data;

  msex_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (en),
    .raddr (ex.mem_index[DA_W-1:0]),
    .rdata (dm_rdata)
  );

  assign s2_wval = s2_load ? dm_rdata : s2.written_value;

  // Pipeline valids, architectural state and bypass valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      out_valid     <= 1'b0;
      fwd_valid     <= 1'b0;
      program_index <= '0;
      halt_flag     <= 1'b0;
    end else if (en) begin
      s1_valid  <= accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
      fwd_valid <= rf_wb;
      if (s1_valid) begin
        program_index <= ex.next_index;
        halt_flag     <= ex.halted;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1.operation    <= inst.operation;
      s1.src_reg      <= inst.src_reg;
      s1.second_reg   <= inst.second_reg;
      s1.dest_reg     <= inst.dest_reg;
      s1.shift_amount <= inst.shift_amount;
      s1.immediate    <= inst.immediate;
      s1.preload_word <= inst.preload_word;
      s1.imm_off      <= inst.immediate - data_base;
      s1_rs_ok        <= (WORD_W'(inst.src_reg) < WORD_W'(REG_COUNT));
      s1_rt_ok        <= (WORD_W'(inst.second_reg) < WORD_W'(REG_COUNT));

      s2.executed_index <= program_index;
      s2.next_index     <= ex.next_index;
      s2.halted         <= ex.halted;
      s2.reg_written    <= ex.reg_written;
      s2.written_reg    <= ex.written_reg;
      s2.written_value  <= ex.value;
      s2.mem_written    <= ex.mem_written;
      s2.mem_word_index <= ex.mem_written ? ex.mem_index[MEM_IDX_W-1:0] : '0;
      s2_load           <= ex.load;

      out_q.executed_index <= s2.executed_index;
      out_q.next_index     <= s2.next_index;
      out_q.halted         <= s2.halted;
      out_q.reg_written    <= s2.reg_written;
      out_q.written_reg    <= s2.written_reg;
      out_q.written_value  <= s2_wval;
      out_q.mem_written    <= s2.mem_written;
      out_q.mem_word_index <= s2.mem_word_index;

      fwd_num <= s2.written_reg;
      fwd_val <= s2_wval;
    end
  end

  // Result channel
  assign result.valid          = out_valid;
  assign result.executed_index = out_q.executed_index;
  assign result.next_index     = out_q.next_index;
  assign result.halted         = out_q.halted;
  assign result.reg_written    = out_q.reg_written;
  assign result.written_reg    = out_q.written_reg;
  assign result.written_value  = out_q.written_value;
  assign result.mem_written    = out_q.mem_written;
  assign result.mem_word_index = out_q.mem_word_index;

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag dropped without reset");

  // Once halted the program index no longer moves
  a_halt_index: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> $stable(program_index))
    else $error("program index moved while halted");

  // No item writes both a register and data memory
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.mem_written |-> !out_q.reg_written)
    else $error("result reports register and memory write together");

  // Register fields are zero when no register is written
  a_wr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_q.reg_written |-> (out_q.written_value == '0) && (out_q.written_reg == '0))
    else $error("register write fields nonzero without a write");

endmodule
